>>> rtl/cse_pkg.sv
// Shared types, field widths and codes of the code book symbol expander.
`default_nettype none
package cse_pkg;

    localparam int unsigned ACT_W  = 2;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned PACK_W = 32;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CNT_W  = 32;

    // slave tdata layout, lowest field first
    localparam int unsigned IN_IDX_LSB  = 0;
    localparam int unsigned IN_LEN_LSB  = IN_IDX_LSB + IDX_W;
    localparam int unsigned IN_PACK_LSB = IN_LEN_LSB + LEN_W;
    localparam int unsigned IN_CODE_LSB = IN_PACK_LSB + PACK_W;
    localparam int unsigned IN_USED_W   = IN_CODE_LSB + IDX_W;
    localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // master tdata layout: symbol, length_ok, decoded_count
    localparam int unsigned OUT_USED_W = SYM_W + 1 + CNT_W;
    localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_END    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic {
        KIND_SYMBOL = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_READ   = 2'd1,
        ST_EMIT   = 2'd2,
        ST_STATUS = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_shift_ctl;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             busy;
    } t_shift_sts;

endpackage
`default_nettype wire

>>> rtl/cse_book.sv
// Code book store: packed symbols and lengths, valid bits, registered read.
`default_nettype none
module cse_book (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr_en,
    input  wire logic [cse_pkg::IDX_W-1:0]   i_wr_idx,
    input  wire logic [cse_pkg::LEN_W-1:0]   i_wr_len,
    input  wire logic [cse_pkg::PACK_W-1:0]  i_wr_sym,
    input  wire logic                        i_rd_en,
    input  wire logic [cse_pkg::IDX_W-1:0]   i_rd_idx,
    output logic      [cse_pkg::LEN_W-1:0]   o_rd_len,
    output logic      [cse_pkg::PACK_W-1:0]  o_rd_sym
);

    localparam int unsigned DEPTH = 2 ** cse_pkg::IDX_W;

    logic [cse_pkg::PACK_W-1:0] r_mem_sym [DEPTH];
    logic [cse_pkg::LEN_W-1:0]  r_mem_len [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [cse_pkg::PACK_W-1:0] r_rd_sym;
    logic [cse_pkg::LEN_W-1:0]  r_rd_len;

    // an entry never written reads as length zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_sym[i_wr_idx] <= i_wr_sym;
            r_mem_len[i_wr_idx] <= i_wr_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_sym <= r_mem_sym[i_rd_idx];
            r_rd_len <= r_valid[i_rd_idx] ? r_mem_len[i_rd_idx] : '0;
        end
    end

    assign o_rd_len = r_rd_len;
    assign o_rd_sym = r_rd_sym;

endmodule
`default_nettype wire

>>> rtl/cse_shifter.sv
// Byte-serial symbol shifter: hands out one symbol of an entry per step.
`default_nettype none
module cse_shifter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cse_pkg::t_shift_ctl         i_ctl,
    input  wire logic [cse_pkg::LEN_W-1:0]   i_len,
    input  wire logic [cse_pkg::PACK_W-1:0]  i_packed,
    output cse_pkg::t_shift_sts              o_sts
);

    logic [cse_pkg::PACK_W-1:0] r_data;
    logic [cse_pkg::LEN_W-1:0]  r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_ctl.load) begin
            r_left <= i_len;
        end else if (i_ctl.step) begin
            r_left <= r_left - cse_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_packed;
        end else if (i_ctl.step) begin
            r_data <= {cse_pkg::SYM_W'(0), r_data[cse_pkg::PACK_W-1:cse_pkg::SYM_W]};
        end
    end

    assign o_sts.symbol = r_data[cse_pkg::SYM_W-1:0];
    assign o_sts.last   = (r_left == cse_pkg::LEN_W'(1));
    assign o_sts.busy   = (r_left != '0);

endmodule
`default_nettype wire

>>> rtl/codebook_symbol_expander_unit.sv
// Top level of the code book symbol expander: control, count and output register.
//
// A load item (tuser 0) writes one code book entry. A decode item (tuser 1) for an
// entry of L symbols is accepted, then the registered read of the code book loads
// the byte-wide shifter, which hands out one symbol per cycle while the output is
// not stalled, the last marked by tlast; an empty entry gives nothing. An end item
// (tuser 2) gives one status transfer comparing the saturating symbol count with
// expected_length, then clears the count. Code 3 is taken and ignored. Downstream
// stalls hold both symbol and status transfers. Entry lengths read as zero after
// reset through per-entry valid bits, so no clearing pass is needed. A stored
// length is capped at min(MAX_SYMBOLS, 4).
`default_nettype none
module codebook_symbol_expander_unit #(
    parameter int unsigned MAX_SYMBOLS = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cse_pkg::CNT_W-1:0]       i_cfg_wdata,   // expected_length
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, entry_length, entry_symbols, code_byte, zero pad
    input  wire logic [cse_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [cse_pkg::ACT_W-1:0]       s_axis_tuser,  // action
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // symbol, length_ok, decoded_count, zero pad
    output logic      [cse_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic      [0:0]                      m_axis_tuser,  // kind
    output logic                                 m_axis_tlast
);

    localparam int unsigned PACK_SYMS   = cse_pkg::PACK_W / cse_pkg::SYM_W;
    localparam int unsigned ENTRY_LIMIT = (MAX_SYMBOLS < PACK_SYMS) ? MAX_SYMBOLS : PACK_SYMS;

    cse_pkg::t_state     r_state, n_state;
    cse_pkg::t_action    in_action;
    cse_pkg::t_shift_ctl shift_ctl;
    cse_pkg::t_shift_sts shift_sts;

    logic                        out_free, wr_en, rd_en, emit, status;
    logic [cse_pkg::IDX_W-1:0]   in_idx, in_code;
    logic [cse_pkg::LEN_W-1:0]   in_len, wr_len, rd_len;
    logic [cse_pkg::PACK_W-1:0]  in_pack, rd_sym;
    logic [cse_pkg::CNT_W-1:0]   r_count, r_exp_len, cnt_inc;

    logic                        r_out_valid;
    cse_pkg::t_kind              r_out_kind;
    logic [cse_pkg::SYM_W-1:0]   r_out_sym;
    logic                        r_out_last, r_out_ok;
    logic [cse_pkg::CNT_W-1:0]   r_out_cnt;

    assign in_action = cse_pkg::t_action'(s_axis_tuser);
    assign in_idx    = s_axis_tdata[cse_pkg::IN_IDX_LSB  +: cse_pkg::IDX_W];
    assign in_len    = s_axis_tdata[cse_pkg::IN_LEN_LSB  +: cse_pkg::LEN_W];
    assign in_pack   = s_axis_tdata[cse_pkg::IN_PACK_LSB +: cse_pkg::PACK_W];
    assign in_code   = s_axis_tdata[cse_pkg::IN_CODE_LSB +: cse_pkg::IDX_W];

    assign wr_len = (in_len > cse_pkg::LEN_W'(ENTRY_LIMIT)) ?
                    cse_pkg::LEN_W'(ENTRY_LIMIT) : in_len;

    assign out_free = !r_out_valid || m_axis_tready;

    cse_book u_book (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_idx (in_idx),
        .i_wr_len (wr_len),
        .i_wr_sym (in_pack),
        .i_rd_en  (rd_en),
        .i_rd_idx (in_code),
        .o_rd_len (rd_len),
        .o_rd_sym (rd_sym)
    );

    cse_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (shift_ctl),
        .i_len    (rd_len),
        .i_packed (rd_sym),
        .o_sts    (shift_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        shift_ctl     = '0;
        emit          = 1'b0;
        status        = 1'b0;
        unique case (r_state)
            cse_pkg::ST_IDLE: begin
                // ready is held high here, so valid alone marks a transfer
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    unique case (in_action)
                        cse_pkg::ACT_LOAD:   wr_en = 1'b1;
                        cse_pkg::ACT_DECODE: begin
                            rd_en   = 1'b1;
                            n_state = cse_pkg::ST_READ;
                        end
                        cse_pkg::ACT_END:    n_state = cse_pkg::ST_STATUS;
                        cse_pkg::ACT_NONE:   ;
                    endcase
                end
            end
            cse_pkg::ST_READ: begin
                shift_ctl.load = 1'b1;
                n_state = (rd_len != '0) ? cse_pkg::ST_EMIT : cse_pkg::ST_IDLE;
            end
            cse_pkg::ST_EMIT: begin
                if (out_free) begin
                    emit           = 1'b1;
                    shift_ctl.step = 1'b1;
                    if (shift_sts.last) begin
                        n_state = cse_pkg::ST_IDLE;
                    end
                end
            end
            cse_pkg::ST_STATUS: begin
                if (out_free) begin
                    status  = 1'b1;
                    n_state = cse_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // saturating count after one more symbol
    assign cnt_inc = (r_count == '1) ? r_count : r_count + cse_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_len <= i_cfg_wdata;
            end
            if (emit) begin
                r_count <= cnt_inc;
            end else if (status) begin
                r_count <= '0;
            end
            if (emit || status) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= cse_pkg::KIND_SYMBOL;
            r_out_sym  <= shift_sts.symbol;
            r_out_last <= shift_sts.last;
            r_out_ok   <= 1'b0;
            r_out_cnt  <= cnt_inc;
        end else if (status) begin
            r_out_kind <= cse_pkg::KIND_STATUS;
            r_out_sym  <= '0;
            r_out_last <= 1'b1;
            r_out_ok   <= (r_count == r_exp_len);
            r_out_cnt  <= r_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {cse_pkg::OUT_PAD_W'(0), r_out_cnt, r_out_ok, r_out_sym};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // symbols are only handed out while the shifter still holds some
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cse_pkg::ST_EMIT) |-> shift_sts.busy)
        else $error("emit state with empty shifter");

    // the count only falls through an end-of-stream status
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status |=> (r_count >= $past(r_count)))
        else $error("symbol count fell without a status transfer");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status |=> (r_count == '0) && r_out_last && (r_out_kind == cse_pkg::KIND_STATUS))
        else $error("status transfer did not clear count or mark last");

    // no new item is taken while an entry is being expanded
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_sts.busy |-> !s_axis_tready)
        else $error("input accepted while shifter busy");
`endif

endmodule
`default_nettype wire
